// ----- sv/kab_pkg.sv -----
// Shared constants, types and saturation helper for the angle/bias Kalman filter.
package kab_pkg;

    localparam int DT_FRAC_BITS  = 16;
    localparam int COV_FRAC_BITS = 24;
    // Quotient bits the gain divider produces below the saturation point.
    localparam int GAIN_Q_BITS   = 31;
    localparam int DIV_PRE_BITS  = GAIN_Q_BITS - COV_FRAC_BITS;

    localparam int NOISE_W = 31;
    localparam int WIDE_W  = 48;
    localparam int MUL_A_W = 36;
    localparam int MUL_B_W = 33;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    typedef logic signed [31:0]        t_word;
    typedef logic signed [WIDE_W-1:0]  t_wide;
    typedef logic [NOISE_W-1:0]        t_noise;

    typedef enum logic [1:0] {
        CFG_ANGLE_NOISE = 2'd0,
        CFG_BIAS_NOISE  = 2'd1,
        CFG_MEAS_NOISE  = 2'd2,
        CFG_UNUSED      = 2'd3
    } t_cfg_idx;

    localparam t_noise RST_ANGLE_NOISE = 31'd16777;
    localparam t_noise RST_BIAS_NOISE  = 31'd50332;
    localparam t_noise RST_MEAS_NOISE  = 31'd503316;
    localparam t_word  COV_ONE         = t_word'(64'd1 << COV_FRAC_BITS);

    localparam t_wide WIDE_MAX = t_wide'(64'sd2147483647);
    localparam t_wide WIDE_MIN = t_wide'(-64'sd2147483648);

    function automatic t_word sat32(input t_wide v);
        t_word r;
        if (v > WIDE_MAX) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < WIDE_MIN) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ----- sv/kab_in_if.sv -----
// Sample channel: measured angle, gyro rate and time step.
interface kab_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] measured_angle;
    logic signed [31:0] measured_rate;
    logic [15:0]        time_step;

    modport source (output valid, measured_angle, measured_rate, time_step, input ready);
    modport sink   (input valid, measured_angle, measured_rate, time_step, output ready);
endinterface

// ----- sv/kab_out_if.sv -----
// Result channel: fused angle, unbiased rate and gain fault flag.
interface kab_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] fused_angle;
    logic signed [31:0] unbiased_rate;
    logic               gain_fault;

    modport source (output valid, fused_angle, unbiased_rate, gain_fault, input ready);
    modport sink   (input valid, fused_angle, unbiased_rate, gain_fault, output ready);
endinterface

// ----- sv/kalman_angle_bias_filter.sv -----
// Top level of the two-state angle/bias Kalman filter with its sequencer.
//
// Usage: each beat on i_sample carries a measured angle and gyro rate (Q16.16)
// and a time step (Q0.16 seconds). Each accepted sample gives exactly one beat
// on o_result: the corrected angle, the rate minus the bias held before the
// step, and a fault flag set when the innovation variance was not positive.
// The user must write the three noise registers (i_cfg_we/i_cfg_idx/i_cfg_data)
// only while the block is idle; the block itself does not enforce this.
// Writes to index three are dropped. An accepted sample runs through 6
// prediction steps, the gain divider (31 quotient bits, one per cycle), 7
// correction steps on one shared registered multiplier, and the load of the
// output register. When the innovation variance is not positive the division
// is skipped. One sample is processed at a time: a new sample is accepted only
// once the previous one has been loaded into the output register. The result
// sits in an output register, so the next sample can be accepted while it
// waits; if the receiver stalls beyond that, the block holds its finished
// state until the register frees up.
// Reset restores the noise registers, zero angle and bias, and an identity
// covariance, with no clearing pass.
module kalman_angle_bias_filter
    import kab_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    kab_in_if.sink      i_sample,
    kab_out_if.source   o_result,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [30:0] i_cfg_data
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_PRED = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_CORR = 5'b01000,
        ST_OUT  = 5'b10000
    } t_state;

    t_state r_state;
    logic [2:0] r_step;

    t_noise r_apn, r_bpn, r_mn;
    t_word  r_ang, r_bias, r_p00, r_p01, r_p10, r_p11;
    t_word  r_mangle, r_mrate, r_rate, r_y, r_k0, r_k1;
    logic [15:0] r_dt;
    logic signed [32:0] r_dtp11;
    logic signed [MUL_A_W-1:0] r_inner;
    logic r_fault;

    logic  r_ovalid;
    t_word r_ofused, r_orate;
    logic  r_ofault;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic signed [PROD_W-1:0]  prod_dt, prod_cov;
    t_wide scaled;

    logic signed [33:0] s_var;
    logic  div_start, div_done;
    t_word div_k0, div_k1;
    logic  out_free;

    kab_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    kab_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num0  (r_p00),
        .i_num1  (r_p10),
        .i_den   (s_var[31:0]),
        .o_done  (div_done),
        .o_k0    (div_k0),
        .o_k1    (div_k1)
    );

    assign prod_dt  = prod >>> DT_FRAC_BITS;
    assign prod_cov = prod >>> COV_FRAC_BITS;
    assign scaled   = (r_state == ST_PRED) ? prod_dt[WIDE_W-1:0] : prod_cov[WIDE_W-1:0];

    assign s_var     = 34'(r_p00) + $signed({3'b0, r_mn});
    assign div_start = (r_state == ST_PRED) && (r_step == 3'd5) && !(s_var <= 0);
    assign out_free  = !r_ovalid || o_result.ready;

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_PRED: begin
                case (r_step)
                    3'd0: begin
                        mul_a = $signed({20'b0, r_dt});
                        mul_b = MUL_B_W'(r_p11);
                    end
                    3'd1: begin
                        mul_a = $signed({20'b0, r_dt});
                        mul_b = MUL_B_W'(r_rate);
                    end
                    3'd2: begin
                        mul_a = $signed({20'b0, r_dt});
                        mul_b = $signed({2'b0, r_bpn});
                    end
                    3'd3: begin
                        mul_a = r_inner;
                        mul_b = $signed({17'b0, r_dt});
                    end
                    default: begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            ST_CORR: begin
                case (r_step)
                    3'd0: begin
                        mul_a = MUL_A_W'(r_k0);
                        mul_b = MUL_B_W'(r_y);
                    end
                    3'd1: begin
                        mul_a = MUL_A_W'(r_k1);
                        mul_b = MUL_B_W'(r_y);
                    end
                    3'd2: begin
                        mul_a = MUL_A_W'(r_k0);
                        mul_b = MUL_B_W'(r_p00);
                    end
                    3'd3: begin
                        mul_a = MUL_A_W'(r_k1);
                        mul_b = MUL_B_W'(r_p00);
                    end
                    3'd4: begin
                        mul_a = MUL_A_W'(r_k0);
                        mul_b = MUL_B_W'(r_p01);
                    end
                    3'd5: begin
                        mul_a = MUL_A_W'(r_k1);
                        mul_b = MUL_B_W'(r_p01);
                    end
                    default: begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_apn <= RST_ANGLE_NOISE;
            r_bpn <= RST_BIAS_NOISE;
            r_mn  <= RST_MEAS_NOISE;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ANGLE_NOISE: r_apn <= i_cfg_data;
                CFG_BIAS_NOISE:  r_bpn <= i_cfg_data;
                CFG_MEAS_NOISE:  r_mn  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer and filter state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_step   <= '0;
            r_ovalid <= 1'b0;
            r_ang    <= '0;
            r_bias   <= '0;
            r_p00    <= COV_ONE;
            r_p01    <= '0;
            r_p10    <= '0;
            r_p11    <= COV_ONE;
        end else begin
            if (r_ovalid && o_result.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_sample.valid) begin
                        r_mangle <= i_sample.measured_angle;
                        r_mrate  <= i_sample.measured_rate;
                        r_dt     <= i_sample.time_step;
                        r_step   <= '0;
                        r_state  <= ST_PRED;
                    end
                end
                ST_PRED: begin
                    r_step <= r_step + 1'b1;
                    case (r_step)
                        3'd0: r_rate <= sat32(t_wide'(r_mrate) - t_wide'(r_bias));
                        3'd1: r_dtp11 <= scaled[32:0];
                        3'd2: begin
                            r_ang   <= sat32(t_wide'(r_ang) + scaled);
                            r_inner <= MUL_A_W'(t_wide'(r_dtp11) - t_wide'(r_p01)
                                       - t_wide'(r_p10) + $signed({17'b0, r_apn}));
                            r_p01   <= sat32(t_wide'(r_p01) - t_wide'(r_dtp11));
                            r_p10   <= sat32(t_wide'(r_p10) - t_wide'(r_dtp11));
                        end
                        3'd3: r_p11 <= sat32(t_wide'(r_p11) + scaled);
                        3'd4: begin
                            r_p00 <= sat32(t_wide'(r_p00) + scaled);
                            r_y   <= sat32(t_wide'(r_mangle) - t_wide'(r_ang));
                        end
                        default: begin
                            r_step <= '0;
                            if (s_var <= 0) begin
                                // Gains forced to zero leave the prediction untouched.
                                r_fault <= 1'b1;
                                r_k0    <= '0;
                                r_k1    <= '0;
                                r_state <= ST_CORR;
                            end else begin
                                r_fault <= 1'b0;
                                r_state <= ST_DIV;
                            end
                        end
                    endcase
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_k0    <= div_k0;
                        r_k1    <= div_k1;
                        r_step  <= '0;
                        r_state <= ST_CORR;
                    end
                end
                ST_CORR: begin
                    r_step <= r_step + 1'b1;
                    case (r_step)
                        3'd1: r_ang  <= sat32(t_wide'(r_ang) + scaled);
                        3'd2: r_bias <= sat32(t_wide'(r_bias) + scaled);
                        3'd3: r_p00  <= sat32(t_wide'(r_p00) - scaled);
                        3'd4: r_p10  <= sat32(t_wide'(r_p10) - scaled);
                        3'd5: r_p01  <= sat32(t_wide'(r_p01) - scaled);
                        3'd6: begin
                            r_p11   <= sat32(t_wide'(r_p11) - scaled);
                            r_state <= ST_OUT;
                        end
                        default: ;
                    endcase
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_ofused <= r_ang;
                        r_orate  <= r_rate;
                        r_ofault <= r_fault;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign i_sample.ready         = (r_state == ST_IDLE);
    assign o_result.valid         = r_ovalid;
    assign o_result.fused_angle   = r_ofused;
    assign o_result.unbiased_rate = r_orate;
    assign o_result.gain_fault    = r_ofault;

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV))
        else $error("gain divider finished outside the divide phase");

    a_fault_zero_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CORR && r_fault) |-> (r_k0 == 0 && r_k1 == 0))
        else $error("nonzero gain applied after a gain fault");

    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == ST_OUT))
        else $error("result raised without finishing a sample");

endmodule

// ----- sv/kab_mul.sv -----
// Shared signed multiplier with a registered product.
module kab_mul
    import kab_pkg::*;
(
    input  logic                      i_clk,
    input  logic signed [MUL_A_W-1:0] i_a,
    input  logic signed [MUL_B_W-1:0] i_b,
    output logic signed [PROD_W-1:0]  o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

// ----- sv/kab_div.sv -----
// Two-lane restoring divider for the gains (num << COV_FRAC_BITS) / den, saturated.
module kab_div
    import kab_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_word       i_num0,
    input  t_word       i_num1,
    input  logic [31:0] i_den,
    output logic        o_done,
    output t_word       o_k0,
    output t_word       o_k1
);

    localparam int CNT_W = $clog2(GAIN_Q_BITS);

    logic                   r_busy;
    logic                   r_done;
    logic [CNT_W-1:0]       r_cnt;
    logic [31:0]            r_den;
    logic [31:0]            r_rem  [2];
    logic [GAIN_Q_BITS-1:0] r_nlo  [2];
    logic [GAIN_Q_BITS-1:0] r_q    [2];
    logic                   r_neg  [2];
    logic                   r_over [2];

    t_word       num [2];
    logic [31:0] mag [2];
    t_word       k   [2];

    assign num[0] = i_num0;
    assign num[1] = i_num1;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            mag[l] = num[l][31] ? 32'(-num[l]) : 32'(num[l]);
            if (r_over[l]) begin
                k[l] = r_neg[l] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end else if (r_neg[l]) begin
                k[l] = -$signed({1'b0, r_q[l]});
            end else begin
                k[l] = $signed({1'b0, r_q[l]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(GAIN_Q_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        logic [32:0] t;
        for (int l = 0; l < 2; l++) begin
            t = '0;
            if (i_start) begin
                r_neg[l]  <= num[l][31];
                // A quotient of 2^31 or more only ever lands on the clamp.
                r_over[l] <= {{DIV_PRE_BITS{1'b0}}, mag[l]} >= {i_den, {DIV_PRE_BITS{1'b0}}};
                r_rem[l]  <= mag[l] >> DIV_PRE_BITS;
                r_nlo[l]  <= {mag[l][DIV_PRE_BITS-1:0], {COV_FRAC_BITS{1'b0}}};
                r_q[l]    <= '0;
            end else if (r_busy) begin
                t = {r_rem[l], r_nlo[l][GAIN_Q_BITS-1]};
                if (t >= {1'b0, r_den}) begin
                    r_rem[l] <= 32'(t - {1'b0, r_den});
                    r_q[l]   <= {r_q[l][GAIN_Q_BITS-2:0], 1'b1};
                end else begin
                    r_rem[l] <= t[31:0];
                    r_q[l]   <= {r_q[l][GAIN_Q_BITS-2:0], 1'b0};
                end
                r_nlo[l] <= r_nlo[l] << 1;
            end
        end
        if (i_start) begin
            r_den <= i_den;
        end
    end

    assign o_done = r_done;
    assign o_k0   = k[0];
    assign o_k1   = k[1];

endmodule

// ----- tb/kalman_angle_bias_filter_test.sv -----
// Self-checking testbench for the two-state angle/bias Kalman filter.
`timescale 1ns / 100ps

module kalman_angle_bias_filter_test;
    import kab_pkg::*;

    typedef struct {
        t_word fused;
        t_word rate;
        logic  fault;
    } t_fused_result;

    typedef enum logic [1:0] {
        ROW_SAMPLE,
        ROW_CFG,
        ROW_FAULT
    } t_row_kind;

    typedef struct {
        t_row_kind     kind;
        t_word         angle;
        t_word         rate;
        logic [15:0]   dt;
        t_cfg_idx      idx;
        t_noise        data;
        logic          typed;
        t_fused_result typed_res;
    } t_stim_row;

    localparam int HALF_PERIOD = 2;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 80;
    localparam int RANDOM_ITEMS = 750;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [30:0] i_cfg_data = '0;

    kab_in_if  sample_ch ();
    kab_out_if result_ch ();

    kalman_angle_bias_filter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sample   (sample_ch.sink),
        .o_result   (result_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Filter state and noise settings as the predictor sees them.
    t_noise q_angle, q_bias, r_meas;
    longint est_angle, est_bias, p_aa, p_ab, p_ba, p_bb;

    t_fused_result pending_results[$];
    t_stim_row     directed_rows[$];
    int errors = 0;
    int results_seen = 0;
    int faults_seen = 0;
    int cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off_cycles = 0;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Gain quotient (num << C) / den, truncated toward zero, den positive.
    function automatic longint gain_quot(longint num, longint den);
        longint mag, q;
        mag = (num < 0) ? -num : num;
        q = (mag <<< COV_FRAC_BITS) / den;
        if (q > 64'sd2147483648) q = 64'sd2147483648;
        return clamp32((num < 0) ? -q : q);
    endfunction

    function automatic void filter_reset();
        q_angle = RST_ANGLE_NOISE;
        q_bias = RST_BIAS_NOISE;
        r_meas = RST_MEAS_NOISE;
        est_angle = 0;
        est_bias = 0;
        p_aa = longint'(COV_ONE);
        p_ab = 0;
        p_ba = 0;
        p_bb = longint'(COV_ONE);
    endfunction

    function automatic t_fused_result filter_step(t_word m_angle, t_word m_rate,
                                                  logic [15:0] dt_u);
        t_fused_result res;
        longint dt, rate, ang, b, p00, p01, p10, p11, dtp11, inner, s, y, k0, k1;
        longint p00t, p01t;
        dt = longint'(dt_u);
        res.fault = 1'b0;
        rate = clamp32(longint'(m_rate) - est_bias);
        ang = clamp32(est_angle + ((dt * rate) >>> DT_FRAC_BITS));
        p00 = p_aa;
        p01 = p_ab;
        p10 = p_ba;
        p11 = p_bb;
        dtp11 = (dt * p11) >>> DT_FRAC_BITS;
        inner = dtp11 - p01 - p10 + longint'(q_angle);
        p00 = clamp32(p00 + ((dt * inner) >>> DT_FRAC_BITS));
        p01 = clamp32(p01 - dtp11);
        p10 = clamp32(p10 - dtp11);
        p11 = clamp32(p11 + ((longint'(q_bias) * dt) >>> DT_FRAC_BITS));
        s = p00 + longint'(r_meas);
        if (s <= 0) begin
            k0 = 0;
            k1 = 0;
            res.fault = 1'b1;
        end else begin
            k0 = gain_quot(p00, s);
            k1 = gain_quot(p10, s);
        end
        y = clamp32(longint'(m_angle) - ang);
        b = est_bias;
        ang = clamp32(ang + ((k0 * y) >>> COV_FRAC_BITS));
        b = clamp32(b + ((k1 * y) >>> COV_FRAC_BITS));
        p00t = p00;
        p01t = p01;
        p00 = clamp32(p00 - ((k0 * p00t) >>> COV_FRAC_BITS));
        p01 = clamp32(p01 - ((k0 * p01t) >>> COV_FRAC_BITS));
        p10 = clamp32(p10 - ((k1 * p00t) >>> COV_FRAC_BITS));
        p11 = clamp32(p11 - ((k1 * p01t) >>> COV_FRAC_BITS));
        est_angle = ang;
        est_bias = b;
        p_aa = p00;
        p_ab = p01;
        p_ba = p10;
        p_bb = p11;
        res.fused = t_word'(ang);
        res.rate = t_word'(rate);
        return res;
    endfunction

    task automatic report_mismatch(string what);
        $display("MISMATCH at cycle %0d: %s", cycles, what);
        errors++;
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("kalman_angle_bias_filter test failed");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off on request.
    initial begin
        result_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_cycles > 0) begin
                hold_off_cycles--;
                result_ch.ready = 1'b0;
            end else begin
                result_ch.ready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_fused_result want;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            results_seen++;
            if (result_ch.gain_fault) faults_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("result beat with nothing outstanding");
            end else begin
                want = pending_results.pop_front();
                if (result_ch.fused_angle !== want.fused)
                    report_mismatch($sformatf("fused_angle %h, want %h",
                                              result_ch.fused_angle, want.fused));
                if (result_ch.unbiased_rate !== want.rate)
                    report_mismatch($sformatf("unbiased_rate %h, want %h",
                                              result_ch.unbiased_rate, want.rate));
                if (result_ch.gain_fault !== want.fault)
                    report_mismatch($sformatf("gain_fault %b, want %b",
                                              result_ch.gain_fault, want.fault));
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic send_sample(t_word a, t_word r, logic [15:0] dt, logic force_fault,
                               logic typed, t_fused_result typed_res);
        t_fused_result res;
        while ($urandom_range(99) < send_idle_pct) begin
            sample_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        sample_ch.valid = 1'b1;
        sample_ch.measured_angle = a;
        sample_ch.measured_rate = r;
        sample_ch.time_step = dt;
        @(posedge i_clk);
        while (!sample_ch.ready) @(posedge i_clk);
        res = filter_step(a, r, dt);
        if (force_fault) res.fault = 1'b1;
        pending_results.push_back(typed ? typed_res : res);
        @(negedge i_clk);
    endtask

    // Drain, let the pipeline settle, then write a register.
    task automatic write_noise(t_cfg_idx idx, t_noise data);
        sample_ch.valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_ANGLE_NOISE: q_angle = data;
            CFG_BIAS_NOISE:  q_bias = data;
            CFG_MEAS_NOISE:  r_meas = data;
            default: ;
        endcase
    endtask

    function automatic t_word rand_fixed();
        case ($urandom_range(3))
            0: return t_word'($urandom);
            1: return t_word'($signed($urandom_range(2000 << 16)) - (1000 << 16));
            default: return t_word'($signed($urandom_range(180 << 16)) - (90 << 16));
        endcase
    endfunction

    function automatic logic [15:0] rand_dt();
        case ($urandom_range(9))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom);
            default: return 16'($urandom_range(1 << 12));
        endcase
    endfunction

    function automatic void add_row(t_row_kind kind, t_word a, t_word r, logic [15:0] dt,
                                    t_cfg_idx idx, t_noise data);
        t_stim_row row;
        row.kind = kind;
        row.angle = a;
        row.rate = r;
        row.dt = dt;
        row.idx = idx;
        row.data = data;
        row.typed = 1'b0;
        row.typed_res = '{t_word'(0), t_word'(0), 1'b0};
        directed_rows.push_back(row);
    endfunction

    initial begin
        t_fused_result none;
        t_stim_row row;
        int phase;
        int setting;
        none = '{t_word'(0), t_word'(0), 1'b0};
        filter_reset();
        sample_ch.valid = 1'b0;
        sample_ch.measured_angle = '0;
        sample_ch.measured_rate = '0;
        sample_ch.time_step = '0;

        // Out of reset with all-zero input nothing moves.
        add_row(ROW_SAMPLE, '0, '0, 16'd0, CFG_ANGLE_NOISE, 31'd0);
        directed_rows[0].typed = 1'b1;
        add_row(ROW_SAMPLE, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'hFFFF, CFG_ANGLE_NOISE, 31'd0);
        add_row(ROW_SAMPLE, 32'sh8000_0000, 32'sh8000_0000, 16'hFFFF, CFG_ANGLE_NOISE, 31'd0);
        add_row(ROW_SAMPLE, 32'sh7FFF_FFFF, 32'sh8000_0000, 16'd1, CFG_ANGLE_NOISE, 31'd0);
        add_row(ROW_SAMPLE, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'd0, CFG_ANGLE_NOISE, 31'd0);
        add_row(ROW_SAMPLE, 32'sh0001_0000, 32'sh0000_8000, 16'd655, CFG_ANGLE_NOISE, 31'd0);
        add_row(ROW_CFG, '0, '0, 16'd0, CFG_UNUSED, 31'h7FFF_FFFF);
        add_row(ROW_CFG, '0, '0, 16'd0, CFG_ANGLE_NOISE, 31'h7FFF_FFFF);
        add_row(ROW_CFG, '0, '0, 16'd0, CFG_BIAS_NOISE, 31'h7FFF_FFFF);
        add_row(ROW_SAMPLE, 32'sh0010_0000, -32'sh0010_0000, 16'hFFFF, CFG_ANGLE_NOISE, 31'd0);
        add_row(ROW_SAMPLE, 32'sh0010_0000, -32'sh0010_0000, 16'hFFFF, CFG_ANGLE_NOISE, 31'd0);
        // With no measurement noise the first step drives the angle variance to
        // zero, so a following zero step leaves S at zero and the gains fault.
        add_row(ROW_CFG, '0, '0, 16'd0, CFG_ANGLE_NOISE, 31'd0);
        add_row(ROW_CFG, '0, '0, 16'd0, CFG_MEAS_NOISE, 31'd0);
        add_row(ROW_SAMPLE, 32'sh0005_0000, 32'sh0001_0000, 16'd0, CFG_ANGLE_NOISE, 31'd0);
        add_row(ROW_FAULT, 32'sh0007_0000, 32'sh0002_0000, 16'd0, CFG_ANGLE_NOISE, 31'd0);
        add_row(ROW_SAMPLE, -32'sh0003_0000, 32'sh0000_0001, 16'd100, CFG_ANGLE_NOISE, 31'd0);

        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[n]) begin
            row = directed_rows[n];
            if (row.kind == ROW_CFG)
                write_noise(row.idx, row.data);
            else
                send_sample(row.angle, row.rate, row.dt, row.kind == ROW_FAULT,
                            row.typed, row.typed_res);
        end

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
                default: begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            for (setting = 0; setting < 3; setting++) begin
                case ((phase + setting) % 4)
                    0: begin
                        write_noise(CFG_ANGLE_NOISE, RST_ANGLE_NOISE);
                        write_noise(CFG_BIAS_NOISE, RST_BIAS_NOISE);
                        write_noise(CFG_MEAS_NOISE, RST_MEAS_NOISE);
                    end
                    1: begin
                        write_noise(CFG_ANGLE_NOISE, 31'h7FFF_FFFF);
                        write_noise(CFG_BIAS_NOISE, 31'd0);
                        write_noise(CFG_MEAS_NOISE, 31'h7FFF_FFFF);
                    end
                    2: begin
                        write_noise(CFG_ANGLE_NOISE, 31'd0);
                        write_noise(CFG_BIAS_NOISE, 31'h7FFF_FFFF);
                        write_noise(CFG_MEAS_NOISE, 31'd0);
                    end
                    default: begin
                        write_noise(CFG_ANGLE_NOISE, 31'($urandom));
                        write_noise(CFG_BIAS_NOISE, 31'($urandom_range(1 << 22)));
                        write_noise(CFG_MEAS_NOISE, 31'($urandom_range(1 << 24)));
                        write_noise(CFG_UNUSED, 31'($urandom));
                    end
                endcase
                // The receiver holds off while samples keep coming, so the
                // block backs up and stalls its input.
                if (phase == 0 && setting == 0) hold_off_cycles = 400;
                repeat (RANDOM_ITEMS / 12)
                    send_sample(rand_fixed(), rand_fixed(), rand_dt(), 1'b0, 1'b0, none);
            end
        end

        sample_ch.valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Covered %0d result beats (%0d with a gain fault) over four idle patterns,",
                 results_seen, faults_seen);
        $display("default, extreme and random noise settings, and one long receiver hold-off.");
        if (errors == 0) begin
            $display("kalman_angle_bias_filter test passed");
        end else begin
            $display("%0d mismatches", errors);
            $display("kalman_angle_bias_filter test failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/kab_pkg.sv
sv/kab_in_if.sv
sv/kab_out_if.sv
sv/kab_mul.sv
sv/kab_div.sv
sv/kalman_angle_bias_filter.sv
tb/kalman_angle_bias_filter_test.sv
